@@ hdl/vsa_pkg.sv @@
package vsa_pkg;

  // scoring function codes, as written to the configuration register
  typedef enum logic [2:0] {
    FN_RAW          = 3'd0,
    FN_GROUNDED     = 3'd1,
    FN_TRANSFORMED  = 3'd2,
    FN_JACCARD      = 3'd3,
    FN_MOD_JACCARD  = 3'd4
  } sim_fn_t;

  localparam int ELEM_W      = 16;  // Q1.15 element
  localparam int PROD_W      = 32;  // Q.30 product
  localparam int TERM_W      = 18;  // min / max / abs-sum term, Q.15
  localparam int DOT_W       = 48;  // dot accumulator, Q.30
  localparam int ACC_W       = 32;  // min / max accumulators, Q.15
  localparam int SIM_W       = 32;  // Q16.16 result
  localparam int QUOT_W      = 48;  // divider dividend and quotient
  localparam int QUEUE_DEPTH = 4;

  // one classified pair handed from the front to the back
  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic signed [TERM_W-1:0] min_term;
    logic signed [TERM_W-1:0] max_term;
    logic                     min_en;
    logic                     last;
    sim_fn_t                  fn;
  } vsa_item_t;

  typedef enum logic [1:0] {
    BK_ACC,
    BK_FINISH,
    BK_DIVIDE,
    BK_OUTPUT
  } back_state_t;

endpackage

@@ hdl/vector_similarity_accumulator.sv @@
// channel   direction  handshake                       payload
// s_axis    in         s_axis_tvalid / s_axis_tready   element pair, tlast = last pair
// m_axis    out        m_axis_tvalid / m_axis_tready   similarity, tuser = divide by zero
// cfg       in         cfg_valid / cfg_ready           function select
//
// One pair per cycle is taken while the accumulator stage keeps up.
// After a closing pair the back end passes through its finish and output states,
// jaccard with a nonzero max also through divide (one quotient bit per cycle in the shared divider);
// the queue ahead of the back end holds up to four pairs before s_axis_tready drops.
// Reset clears the queue, accumulators and output valid flag, and selects grounded cosine.
// A stalled m_axis holds the score while new pairs still enter the queue.
module vector_similarity_accumulator #(
  parameter int MAX_VECTOR_LENGTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] ref_element, [31:16] hyp_element
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] similarity
  output logic        m_axis_tuser    // [0] divide_by_zero
);

  vsa_pkg::vsa_item_t push_item, pop_item;
  logic               q_push, q_pop, q_full, q_empty;
  logic signed [vsa_pkg::SIM_W-1:0] sim;

  vsa_front #(
    .MAX_VECTOR_LENGTH (MAX_VECTOR_LENGTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .ref_element  (s_axis_tdata[15:0]),
    .hyp_element  (s_axis_tdata[31:16]),
    .last_element (s_axis_tlast),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (push_item)
  );

  vsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  vsa_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (pop_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_sim   (sim),
    .out_dz    (m_axis_tuser)
  );

  assign m_axis_tdata = sim;

endmodule

@@ hdl/vsa_front.sv @@
module vsa_front #(
  parameter int MAX_VECTOR_LENGTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [vsa_pkg::ELEM_W-1:0]   ref_element,
  input  logic signed [vsa_pkg::ELEM_W-1:0]   hyp_element,
  input  logic                                last_element,
  input  logic                                q_full,
  output logic                                q_push,
  output vsa_pkg::vsa_item_t                  q_item
);

  localparam int CNT_W = $clog2(MAX_VECTOR_LENGTH + 1);

  logic [2:0]                     fn_sel;
  vsa_pkg::sim_fn_t               fn;
  logic [CNT_W-1:0]               cnt;
  logic                           final_pair;
  logic signed [vsa_pkg::ELEM_W:0] r_ext, h_ext;
  logic [vsa_pkg::ELEM_W:0]       r_abs, h_abs;
  logic                           both_pos;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;

  // function select register
  always_ff @(posedge clk) begin
    if (rst) begin
      fn_sel <= 3'(vsa_pkg::FN_GROUNDED);
    end else if (cfg_valid && cfg_ready) begin
      fn_sel <= cfg_data;
    end
  end

  // codes above the list act as grounded cosine
  always_comb begin
    case (fn_sel)
      3'(vsa_pkg::FN_RAW):         fn = vsa_pkg::FN_RAW;
      3'(vsa_pkg::FN_TRANSFORMED): fn = vsa_pkg::FN_TRANSFORMED;
      3'(vsa_pkg::FN_JACCARD):     fn = vsa_pkg::FN_JACCARD;
      3'(vsa_pkg::FN_MOD_JACCARD): fn = vsa_pkg::FN_MOD_JACCARD;
      default:                     fn = vsa_pkg::FN_GROUNDED;
    endcase
  end

  // pair counter, forces the end of an over-long vector
  assign final_pair = last_element || (cnt == CNT_W'(MAX_VECTOR_LENGTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (q_push) begin
      cnt <= final_pair ? '0 : cnt + 1'b1;
    end
  end

  // classify the pair
  always_comb begin
    r_ext    = {ref_element[vsa_pkg::ELEM_W-1], ref_element};
    h_ext    = {hyp_element[vsa_pkg::ELEM_W-1], hyp_element};
    r_abs    = r_ext[vsa_pkg::ELEM_W] ? -r_ext : r_ext;
    h_abs    = h_ext[vsa_pkg::ELEM_W] ? -h_ext : h_ext;
    both_pos = !ref_element[vsa_pkg::ELEM_W-1] && !hyp_element[vsa_pkg::ELEM_W-1];

    q_item.prod = ref_element * hyp_element;
    q_item.last = final_pair;
    q_item.fn   = fn;
    if (fn != vsa_pkg::FN_MOD_JACCARD || both_pos) begin
      q_item.min_en   = 1'b1;
      q_item.min_term = (ref_element < hyp_element) ? {{2{r_ext[vsa_pkg::ELEM_W]}}, ref_element}
                                                    : {{2{h_ext[vsa_pkg::ELEM_W]}}, hyp_element};
      q_item.max_term = (ref_element < hyp_element) ? {{2{h_ext[vsa_pkg::ELEM_W]}}, hyp_element}
                                                    : {{2{r_ext[vsa_pkg::ELEM_W]}}, ref_element};
    end else begin
      // negative element in modified jaccard: denominator only
      q_item.min_en   = 1'b0;
      q_item.min_term = '0;
      q_item.max_term = vsa_pkg::TERM_W'(r_abs) + vsa_pkg::TERM_W'(h_abs);
    end
  end

endmodule

@@ hdl/vsa_queue.sv @@
module vsa_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vsa_pkg::vsa_item_t push_item,
  output logic               full,
  input  logic               pop,
  output vsa_pkg::vsa_item_t pop_item,
  output logic               empty
);

  localparam int PTR_W = $clog2(vsa_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(vsa_pkg::QUEUE_DEPTH + 1);

  vsa_pkg::vsa_item_t slots [vsa_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full     = (fill == CNT_W'(vsa_pkg::QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_item = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ hdl/vsa_divider.sv @@
module vsa_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [vsa_pkg::QUOT_W-1:0] dividend,
  input  logic [vsa_pkg::ACC_W-1:0]  divisor,
  output logic                       done,
  output logic [vsa_pkg::QUOT_W-1:0] quotient
);

  localparam int STEP_W = $clog2(vsa_pkg::QUOT_W);

  logic [vsa_pkg::QUOT_W-1:0] dq;
  logic [vsa_pkg::ACC_W-1:0]  rem, dvs;
  logic [vsa_pkg::ACC_W:0]    trial, diff;
  logic                       ge;
  logic [STEP_W-1:0]          step;
  logic                       busy;

  assign quotient = dq;

  // one restoring step per cycle
  always_comb begin
    trial = {rem, dq[vsa_pkg::QUOT_W-1]};
    ge    = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == STEP_W'(vsa_pkg::QUOT_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq   <= dividend;
      rem  <= '0;
      dvs  <= divisor;
      step <= '0;
    end else if (busy) begin
      dq   <= {dq[vsa_pkg::QUOT_W-2:0], ge};
      rem  <= ge ? diff[vsa_pkg::ACC_W-1:0] : trial[vsa_pkg::ACC_W-1:0];
      step <= step + 1'b1;
    end
  end

endmodule

@@ hdl/vsa_back.sv @@
module vsa_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_empty,
  output logic                              q_pop,
  input  vsa_pkg::vsa_item_t                q_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [vsa_pkg::SIM_W-1:0]  out_sim,
  output logic                              out_dz
);

  localparam logic signed [vsa_pkg::SIM_W-1:0] SIM_MAX = {1'b0, {(vsa_pkg::SIM_W-1){1'b1}}};
  localparam logic signed [vsa_pkg::SIM_W-1:0] SIM_MIN = {1'b1, {(vsa_pkg::SIM_W-1){1'b0}}};

  vsa_pkg::back_state_t state, state_next;

  logic signed [vsa_pkg::DOT_W-1:0] dot_acc, f_dot;
  logic signed [vsa_pkg::ACC_W-1:0] min_acc, max_acc, f_min, f_max;
  vsa_pkg::sim_fn_t                 f_fn;
  logic signed [vsa_pkg::SIM_W-1:0] res_sim;
  logic                             res_dz;

  logic signed [vsa_pkg::DOT_W:0]   dot_sum, rnd_cos, rnd_trn;
  logic signed [vsa_pkg::ACC_W:0]   min_sum, max_sum;
  logic signed [vsa_pkg::DOT_W-1:0] dot_new;
  logic signed [vsa_pkg::ACC_W-1:0] min_new, max_new;
  logic signed [vsa_pkg::SIM_W-1:0] cos_sim;
  logic [vsa_pkg::ACC_W-1:0]        min_abs, max_abs;
  logic                             is_jac, jac_neg;
  logic [vsa_pkg::QUOT_W-1:0]       div_dividend, div_quot;
  logic signed [vsa_pkg::SIM_W-1:0] jac_sim;
  logic                             div_start, div_done, load_out;

  function automatic logic signed [vsa_pkg::DOT_W-1:0] sat_dot(
      input logic signed [vsa_pkg::DOT_W:0] v);
    if (v[vsa_pkg::DOT_W] != v[vsa_pkg::DOT_W-1]) begin
      return v[vsa_pkg::DOT_W] ? {1'b1, {(vsa_pkg::DOT_W-1){1'b0}}}
                               : {1'b0, {(vsa_pkg::DOT_W-1){1'b1}}};
    end
    return v[vsa_pkg::DOT_W-1:0];
  endfunction

  function automatic logic signed [vsa_pkg::ACC_W-1:0] sat_acc(
      input logic signed [vsa_pkg::ACC_W:0] v);
    if (v[vsa_pkg::ACC_W] != v[vsa_pkg::ACC_W-1]) begin
      return v[vsa_pkg::ACC_W] ? {1'b1, {(vsa_pkg::ACC_W-1){1'b0}}}
                               : {1'b0, {(vsa_pkg::ACC_W-1){1'b1}}};
    end
    return v[vsa_pkg::ACC_W-1:0];
  endfunction

  function automatic logic signed [vsa_pkg::SIM_W-1:0] sat_sim(
      input logic signed [vsa_pkg::DOT_W:0] v);
    logic [vsa_pkg::DOT_W-vsa_pkg::SIM_W+1:0] top;
    top = v[vsa_pkg::DOT_W:vsa_pkg::SIM_W-1];
    if (&top || ~|top) return v[vsa_pkg::SIM_W-1:0];
    return v[vsa_pkg::DOT_W] ? SIM_MIN : SIM_MAX;
  endfunction

  vsa_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (max_abs),
    .done     (div_done),
    .quotient (div_quot)
  );

  // saturating accumulate of the head pair
  always_comb begin
    dot_sum = {dot_acc[vsa_pkg::DOT_W-1], dot_acc}
            + {{(vsa_pkg::DOT_W+1-vsa_pkg::PROD_W){q_item.prod[vsa_pkg::PROD_W-1]}},
               q_item.prod};
    min_sum = {min_acc[vsa_pkg::ACC_W-1], min_acc}
            + {{(vsa_pkg::ACC_W+1-vsa_pkg::TERM_W){q_item.min_term[vsa_pkg::TERM_W-1]}},
               q_item.min_term};
    max_sum = {max_acc[vsa_pkg::ACC_W-1], max_acc}
            + {{(vsa_pkg::ACC_W+1-vsa_pkg::TERM_W){q_item.max_term[vsa_pkg::TERM_W-1]}},
               q_item.max_term};
    dot_new = sat_dot(dot_sum);
    min_new = q_item.min_en ? sat_acc(min_sum) : min_acc;
    max_new = sat_acc(max_sum);
  end

  // cosine scores: round Q.30 to Q16.16; transformed adds one, then halves
  always_comb begin
    rnd_cos = {f_dot[vsa_pkg::DOT_W-1], f_dot} + 49'sd8192;
    rnd_trn = {f_dot[vsa_pkg::DOT_W-1], f_dot} + 49'sd1073758208;
    case (f_fn)
      vsa_pkg::FN_RAW:         cos_sim = sat_sim(rnd_cos >>> 14);
      vsa_pkg::FN_TRANSFORMED: cos_sim = sat_sim(rnd_trn >>> 15);
      default:                 cos_sim = (f_dot > 0) ? sat_sim(rnd_cos >>> 14) : '0;
    endcase
  end

  // jaccard: |min| * 2^16 + |max| / 2, divided by |max|, sign put back after
  always_comb begin
    is_jac       = (f_fn == vsa_pkg::FN_JACCARD) || (f_fn == vsa_pkg::FN_MOD_JACCARD);
    min_abs      = f_min[vsa_pkg::ACC_W-1] ? -f_min : f_min;
    max_abs      = f_max[vsa_pkg::ACC_W-1] ? -f_max : f_max;
    jac_neg      = f_min[vsa_pkg::ACC_W-1] ^ f_max[vsa_pkg::ACC_W-1];
    div_dividend = {min_abs, 16'b0} + vsa_pkg::QUOT_W'(max_abs[vsa_pkg::ACC_W-1:1]);
    if (jac_neg) begin
      jac_sim = (div_quot > vsa_pkg::QUOT_W'(48'h8000_0000)) ? SIM_MIN
              : -div_quot[vsa_pkg::SIM_W-1:0];
    end else begin
      jac_sim = (div_quot > vsa_pkg::QUOT_W'(48'h7FFF_FFFF)) ? SIM_MAX
              : div_quot[vsa_pkg::SIM_W-1:0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vsa_pkg::BK_ACC;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      vsa_pkg::BK_ACC: begin
        q_pop = !q_empty;
        if (!q_empty && q_item.last) state_next = vsa_pkg::BK_FINISH;
      end
      vsa_pkg::BK_FINISH: begin
        if (is_jac && f_max != '0) begin
          div_start  = 1'b1;
          state_next = vsa_pkg::BK_DIVIDE;
        end else begin
          state_next = vsa_pkg::BK_OUTPUT;
        end
      end
      vsa_pkg::BK_DIVIDE: begin
        if (div_done) state_next = vsa_pkg::BK_OUTPUT;
      end
      vsa_pkg::BK_OUTPUT: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = vsa_pkg::BK_ACC;
        end
      end
      default: state_next = vsa_pkg::BK_ACC;
    endcase
  end

  // accumulators, cleared once a vector closes
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc <= '0;
      min_acc <= '0;
      max_acc <= '0;
    end else if (q_pop) begin
      if (q_item.last) begin
        dot_acc <= '0;
        min_acc <= '0;
        max_acc <= '0;
      end else begin
        dot_acc <= dot_new;
        min_acc <= min_new;
        max_acc <= max_new;
      end
    end
  end

  // final totals and score
  always_ff @(posedge clk) begin
    if (q_pop && q_item.last) begin
      f_dot <= dot_new;
      f_min <= min_new;
      f_max <= max_new;
      f_fn  <= q_item.fn;
    end
    if (state == vsa_pkg::BK_FINISH) begin
      res_sim <= is_jac ? '0 : cos_sim;
      res_dz  <= is_jac && (f_max == '0);
    end else if (state == vsa_pkg::BK_DIVIDE && div_done) begin
      res_sim <= jac_sim;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sim <= res_sim;
      out_dz  <= res_dz;
    end
  end

`ifndef SYNTH
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_dz) |-> (out_sim == '0))
    else $error("divide by zero result is not zero");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_item.last) |=> (dot_acc == '0 && min_acc == '0 && max_acc == '0))
    else $error("accumulators not cleared after final pair");

  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == vsa_pkg::BK_FINISH && is_jac && f_max != '0))
    else $error("divider started outside a jaccard finish");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == vsa_pkg::BK_DIVIDE && div_done) |=> (state == vsa_pkg::BK_OUTPUT))
    else $error("quotient not passed to output");
`endif

endmodule
